// ----- hw/rtl/slp_pkg.sv -----
// Shared types, constants and helper functions of the storage unit label parser.
package slp_pkg;

    // Byte positions within the 80-byte label.
    localparam logic [6:0] POS_SEQ_LAST  = 7'd3;
    localparam logic [6:0] POS_VER_V     = 7'd4;
    localparam logic [6:0] POS_VER_MAJOR = 7'd5;
    localparam logic [6:0] POS_VER_DOT   = 7'd6;
    localparam logic [6:0] POS_VER_TENS  = 7'd7;
    localparam logic [6:0] POS_VER_UNITS = 7'd8;
    localparam logic [6:0] POS_REC_FIRST = 7'd9;
    localparam logic [6:0] POS_LEN_FIRST = 7'd15;
    localparam logic [6:0] POS_LEN_LAST  = 7'd19;
    localparam logic [6:0] POS_ID_FIRST  = 7'd20;
    localparam logic [6:0] POS_LAST      = 7'd79;
    localparam logic [6:0] LABEL_BYTES   = 7'd80;

    // Characters and the supported version 1.00.
    localparam logic [7:0] CHAR_V       = 8'h56;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [3:0] VER_MAJOR_ONE = 4'd1;
    localparam logic [6:0] VER_MINOR_ONE = 7'd0;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Phase of a whitespace-padded decimal field.
    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_TRAIL,
        PH_BAD
    } t_phase;

    // Label summary status codes.
    typedef enum logic [1:0] {
        ST_OK,
        ST_INCONSISTENT,
        ST_UNSUPPORTED
    } t_status;

    // One result item.
    typedef struct packed {
        logic        is_summary;
        logic [7:0]  id_byte;
        logic [13:0] seq_number;
        logic        seq_ok;
        logic [16:0] max_len;
        logic        len_ok;
        logic        structure_ok;
        logic [3:0]  major;
        logic [6:0]  minor;
        logic        version_parsed;
        t_status     status;
        logic        last;
    } t_result;

    // Results produced by one label byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // Whitespace is HT, LF, VT, FF, CR and space.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Expected text of the structure field.
    function automatic logic [7:0] record_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h52;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h43;
            3'd3:    c = 8'h4F;
            3'd4:    c = 8'h52;
            3'd5:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/storage_unit_label_parser_core.sv -----
// Storage unit label parser: takes label bytes one per cycle and gives identifier and summary items.
// A label enters as 80 bytes, one per cycle while not stalled, with start_label on the first byte.
// Each byte is registered, decoded in the next cycle, and its results are written to an
// eight-entry result queue whose head drives the output ports. Bytes 20 to 79 each give
// one identifier item unless the version parsed as something other than 1.00; byte 79
// also gives the summary item, so a label yields up to 61 items for 80 bytes and the
// block sustains one byte per cycle when the output side takes one item per cycle. The
// input stalls only when the result queue cannot hold two more items beyond the byte in
// flight. Bytes past the 80th give nothing until the next start byte.
module storage_unit_label_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_label,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_summary,
    output logic [7:0]  o_id_byte,
    output logic [13:0] o_seq_number,
    output logic        o_seq_ok,
    output logic [16:0] o_max_len,
    output logic        o_len_ok,
    output logic        o_structure_ok,
    output logic [3:0]  o_major,
    output logic [6:0]  o_minor,
    output logic        o_version_parsed,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    logic             accept;
    slp_pkg::t_push   push;
    slp_pkg::t_result head;

    assign accept = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_label;
        end
    end

    // Field decoder.
    slp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_push  (push)
    );

    // Result queue.
    slp_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_hold    (r_in_valid),
        .i_pop     (!i_stall),
        .o_no_room (o_stall),
        .o_valid   (o_valid),
        .o_head    (head)
    );

    // Output fields from the queue head.
    assign o_is_summary     = head.is_summary;
    assign o_id_byte        = head.id_byte;
    assign o_seq_number     = head.seq_number;
    assign o_seq_ok         = head.seq_ok;
    assign o_max_len        = head.max_len;
    assign o_len_ok         = head.len_ok;
    assign o_structure_ok   = head.structure_ok;
    assign o_major          = head.major;
    assign o_minor          = head.minor;
    assign o_version_parsed = head.version_parsed;
    assign o_status         = head.status;
    assign o_last           = head.last;

endmodule

// ----- hw/rtl/slp_parse.sv -----
// Per-byte label field decoder that holds the label state and forms the result items.
module slp_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    output slp_pkg::t_push o_push
);

    logic [6:0]      r_pos,       n_pos,       c_pos;
    slp_pkg::t_phase r_phase,     n_phase,     c_phase;
    logic            r_ended,     n_ended,     c_ended;
    logic [13:0]     r_seq,       n_seq,       c_seq;
    logic            r_seq_valid, n_seq_valid, c_seq_valid;
    logic [16:0]     r_len,       n_len,       c_len;
    logic            r_len_valid, n_len_valid, c_len_valid;
    logic            r_rec,       n_rec,       c_rec;
    logic [3:0]      r_vmaj,      n_vmaj,      c_vmaj;
    logic [6:0]      r_vmin,      n_vmin,      c_vmin;
    logic            r_vmatch,    n_vmatch,    c_vmatch;

    logic            active;
    logic            in_seq;
    logic            in_len;
    logic [16:0]     acc_cur;
    logic [16:0]     acc_next;
    logic [3:0]      digit;
    logic            unsupported;
    logic            seq_ok;
    logic            emit_id;
    logic            emit_sum;
    slp_pkg::t_result res_id;
    slp_pkg::t_result res_sum;

    // A start byte sees the cleared label state.
    always_comb begin
        if (i_start) begin
            c_pos       = '0;
            c_phase     = slp_pkg::PH_LEAD;
            c_ended     = 1'b0;
            c_seq       = '0;
            c_seq_valid = 1'b0;
            c_len       = '0;
            c_len_valid = 1'b0;
            c_rec       = 1'b1;
            c_vmaj      = '0;
            c_vmin      = '0;
            c_vmatch    = 1'b1;
        end else begin
            c_pos       = r_pos;
            c_phase     = r_phase;
            c_ended     = r_ended;
            c_seq       = r_seq;
            c_seq_valid = r_seq_valid;
            c_len       = r_len;
            c_len_valid = r_len_valid;
            c_rec       = r_rec;
            c_vmaj      = r_vmaj;
            c_vmin      = r_vmin;
            c_vmatch    = r_vmatch;
        end
    end

    // Field decoding for the byte at the current position.
    always_comb begin
        n_pos       = c_pos;
        n_phase     = c_phase;
        n_ended     = c_ended;
        n_seq       = c_seq;
        n_seq_valid = c_seq_valid;
        n_len       = c_len;
        n_len_valid = c_len_valid;
        n_rec       = c_rec;
        n_vmaj      = c_vmaj;
        n_vmin      = c_vmin;
        n_vmatch    = c_vmatch;

        active   = i_valid && (c_pos < slp_pkg::LABEL_BYTES);
        in_seq   = c_pos <= slp_pkg::POS_SEQ_LAST;
        in_len   = (c_pos >= slp_pkg::POS_LEN_FIRST) && (c_pos <= slp_pkg::POS_LEN_LAST);
        digit    = i_byte[3:0];
        acc_cur  = in_seq ? 17'(c_seq) : c_len;
        acc_next = {acc_cur[13:0], 3'b000} + {acc_cur[15:0], 1'b0} + 17'(digit);

        if (active) begin
            n_pos = c_pos + 7'd1;

            // Sequence number and maximum length share one number scanner.
            if (in_seq || in_len) begin
                if (!c_ended) begin
                    if (i_byte == slp_pkg::CHAR_NUL) begin
                        n_ended = 1'b1;
                    end else if (slp_pkg::is_ws(i_byte)) begin
                        if (c_phase == slp_pkg::PH_DIGITS) begin
                            n_phase = slp_pkg::PH_TRAIL;
                        end
                    end else if (slp_pkg::is_dig(i_byte)) begin
                        if ((c_phase == slp_pkg::PH_LEAD) || (c_phase == slp_pkg::PH_DIGITS)) begin
                            n_phase = slp_pkg::PH_DIGITS;
                            if (in_seq) begin
                                n_seq = acc_next[13:0];
                            end else begin
                                n_len = acc_next;
                            end
                        end else begin
                            n_phase = slp_pkg::PH_BAD;
                        end
                    end else begin
                        n_phase = slp_pkg::PH_BAD;
                    end
                end
                // The last byte of a number field closes it.
                if ((c_pos == slp_pkg::POS_SEQ_LAST) || (c_pos == slp_pkg::POS_LEN_LAST)) begin
                    if (in_seq) begin
                        n_seq_valid = (n_phase == slp_pkg::PH_DIGITS) ||
                                      (n_phase == slp_pkg::PH_TRAIL);
                    end else begin
                        n_len_valid = (n_phase == slp_pkg::PH_DIGITS) ||
                                      (n_phase == slp_pkg::PH_TRAIL);
                    end
                    n_phase = slp_pkg::PH_LEAD;
                    n_ended = 1'b0;
                end
            end

            // Version field: V, major digit, dot, two minor digits.
            if (c_pos == slp_pkg::POS_VER_V) begin
                if (i_byte != slp_pkg::CHAR_V) begin
                    n_vmatch = 1'b0;
                end
            end else if (c_pos == slp_pkg::POS_VER_DOT) begin
                if (i_byte != slp_pkg::CHAR_DOT) begin
                    n_vmatch = 1'b0;
                end
            end else if ((c_pos >= slp_pkg::POS_VER_MAJOR) && (c_pos <= slp_pkg::POS_VER_UNITS)) begin
                if (!slp_pkg::is_dig(i_byte)) begin
                    n_vmatch = 1'b0;
                end else if (c_pos == slp_pkg::POS_VER_MAJOR) begin
                    n_vmaj = digit;
                end else if (c_pos == slp_pkg::POS_VER_TENS) begin
                    n_vmin = 7'(digit) * 7'd10;
                end else begin
                    n_vmin = c_vmin + 7'(digit);
                end
            end

            // Structure field must read RECORD.
            if ((c_pos >= slp_pkg::POS_REC_FIRST) && (c_pos < slp_pkg::POS_LEN_FIRST)) begin
                if (i_byte != slp_pkg::record_char(3'(c_pos - slp_pkg::POS_REC_FIRST))) begin
                    n_rec = 1'b0;
                end
            end
        end

        unsupported = n_vmatch &&
                      !((n_vmaj == slp_pkg::VER_MAJOR_ONE) && (n_vmin == slp_pkg::VER_MINOR_ONE));
        seq_ok      = n_seq_valid && (n_seq != 14'd0);
        emit_id     = active && (c_pos >= slp_pkg::POS_ID_FIRST) && !unsupported;
        emit_sum    = active && (c_pos == slp_pkg::POS_LAST);

        // Identifier item carries only the byte.
        res_id         = '0;
        res_id.id_byte = i_byte;

        // Summary item.
        res_sum                = '0;
        res_sum.is_summary     = 1'b1;
        res_sum.seq_number     = n_seq;
        res_sum.seq_ok         = seq_ok;
        res_sum.max_len        = n_len;
        res_sum.len_ok         = n_len_valid;
        res_sum.structure_ok   = n_rec;
        res_sum.major          = n_vmatch ? n_vmaj : slp_pkg::VER_MAJOR_ONE;
        res_sum.minor          = n_vmatch ? n_vmin : slp_pkg::VER_MINOR_ONE;
        res_sum.version_parsed = n_vmatch;
        res_sum.last           = 1'b1;
        if (unsupported) begin
            res_sum.status = slp_pkg::ST_UNSUPPORTED;
        end else if (n_vmatch && seq_ok && n_len_valid && n_rec) begin
            res_sum.status = slp_pkg::ST_OK;
        end else begin
            res_sum.status = slp_pkg::ST_INCONSISTENT;
        end

        // Order: identifier byte first, then the summary.
        o_push        = '0;
        o_push.first  = res_id;
        o_push.second = res_sum;
        if (emit_id && emit_sum) begin
            o_push.count = 2'd2;
        end else if (emit_id) begin
            o_push.count = 2'd1;
        end else if (emit_sum) begin
            o_push.count = 2'd1;
            o_push.first = res_sum;
        end
    end

    // Label state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= slp_pkg::PH_LEAD;
            r_ended     <= 1'b0;
            r_seq       <= '0;
            r_seq_valid <= 1'b0;
            r_len       <= '0;
            r_len_valid <= 1'b0;
            r_rec       <= 1'b1;
            r_vmaj      <= '0;
            r_vmin      <= '0;
            r_vmatch    <= 1'b1;
        end else if (i_valid) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_ended     <= n_ended;
            r_seq       <= n_seq;
            r_seq_valid <= n_seq_valid;
            r_len       <= n_len;
            r_len_valid <= n_len_valid;
            r_rec       <= n_rec;
            r_vmaj      <= n_vmaj;
            r_vmin      <= n_vmin;
            r_vmatch    <= n_vmatch;
        end
    end

endmodule

// ----- hw/rtl/slp_fifo.sv -----
// Result queue that takes up to two items per cycle and gives one per cycle when popped.
module slp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slp_pkg::t_push   i_push,
    input  logic             i_hold,
    input  logic             i_pop,
    output logic             o_no_room,
    output logic             o_valid,
    output slp_pkg::t_result o_head
);

    slp_pkg::t_result              r_mem [slp_pkg::FIFO_DEPTH];
    logic [slp_pkg::FIFO_AW-1:0]   r_wr, n_wr;
    logic [slp_pkg::FIFO_AW-1:0]   r_rd, n_rd;
    logic [slp_pkg::FIFO_CW-1:0]   r_count, n_count;
    logic [slp_pkg::FIFO_CW-1:0]   reserve;
    logic                          pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    // Room must remain for two items from the byte in flight and two from a new one.
    assign reserve   = i_hold ? slp_pkg::FIFO_CW'(4) : slp_pkg::FIFO_CW'(2);
    assign o_no_room = (r_count + reserve) > slp_pkg::FIFO_CW'(slp_pkg::FIFO_DEPTH);

    // Pointer and fill count updates.
    always_comb begin
        n_wr    = r_wr + slp_pkg::FIFO_AW'(i_push.count);
        n_rd    = r_rd + slp_pkg::FIFO_AW'(pop);
        n_count = r_count + slp_pkg::FIFO_CW'(i_push.count) - slp_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + slp_pkg::FIFO_AW'(1)] <= i_push.second;
        end
    end

endmodule

// ----- hw/rtl/slp_checker.sv -----
// Port-level checks of the label parser, bound to its top level.
module slp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_is_summary,
    input logic [7:0]  o_id_byte,
    input logic        o_seq_ok,
    input logic        o_len_ok,
    input logic        o_structure_ok,
    input logic [3:0]  o_major,
    input logic [6:0]  o_minor,
    input logic        o_version_parsed,
    input logic [1:0]  o_status,
    input logic        o_last
);

    // A stalled item stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output item dropped while stalled");

    // A stalled item keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_id_byte) && $stable(o_is_summary) &&
                               $stable(o_status))
        else $error("output item changed while stalled");

    // Only the summary item closes a label.
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_is_summary))
        else $error("last flag disagrees with item kind");

    // An ok status needs every field good and version 1.00.
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary && (o_status == slp_pkg::ST_OK) |->
            o_version_parsed && o_seq_ok && o_len_ok && o_structure_ok &&
            (o_major == slp_pkg::VER_MAJOR_ONE) && (o_minor == slp_pkg::VER_MINOR_ONE))
        else $error("ok status with a bad field");

    // An unparsed version reports the assumed 1.00 as inconsistent.
    a_assumed_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_summary && !o_version_parsed |->
            (o_major == slp_pkg::VER_MAJOR_ONE) && (o_minor == slp_pkg::VER_MINOR_ONE) &&
            (o_status == slp_pkg::ST_INCONSISTENT))
        else $error("unparsed version not reported as assumed 1.00");

endmodule

bind storage_unit_label_parser_core slp_checker u_slp_checker (.*);
